/* hw/rtl/lir_pkg.sv */
// lir_pkg: widths, register map, reset values and shared types of the
// linear interpolation resampler; no dependencies
package lir_pkg;

  localparam int SAMPLE_W  = 24;                  // source and result samples
  localparam int COUNT_W   = 23;                  // source sample count
  localparam int FRAC_W    = 24;                  // fractional bits of a position
  localparam int RATIO_W   = 30;                  // unsigned Q6.24 step
  localparam int POS_W     = COUNT_W + FRAC_W;    // output position
  localparam int PROD_W    = SAMPLE_W + FRAC_W;   // |b - a| * frac
  localparam int RES_LIMIT = 64;                  // results per item at most
  localparam int RES_CNT_W = $clog2(RES_LIMIT + 1);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // register indexes, taken from paddr bit 2
  localparam logic REG_RATIO_STEP = 1'b0;
  localparam logic REG_MAX_SOURCE = 1'b1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(16777216);
  localparam logic [COUNT_W-1:0] MAX_RESET   = COUNT_W'(8388607);

  typedef struct packed {
    logic [RATIO_W-1:0] ratio_step;
    logic [COUNT_W-1:0] max_source;
  } lir_cfg_t;

  // request to the shared interpolation unit
  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic [FRAC_W-1:0]          frac;
  } lir_mul_req_t;

endpackage

/* hw/rtl/linear_interp_resampler_top.sv */
// linear_interp_resampler_top: one-channel linear interpolation resampler
// depends on lir_pkg, lir_cfg, lir_interp and lir_ctrl
//
// channel  | ports                        | payload
// ---------+------------------------------+-------------------------------------------
// input    | in_tvalid/in_tready          | tdata: sample_in[23:0]; tlast: last_in
// result   | out_tvalid/out_tready        | tdata: sample_out[23:0]; tlast: done_res;
//          |                              | tuser: has_sample[0], too_short[1]
// config   | cfg_psel..cfg_pready (apb)   | 0x0 ratio_step (Q6.24), 0x4 max_source
//
// an item that causes no result passes the block through accept, evaluate and
// finish; each interpolated result adds issue, the shared multiplier's stages and
// emit, and each final-interval zero adds emit; at most 64 results per item
// the newest result is held back one slot so the file's final one can carry tlast
// a stalled result port stops the sequencer only when the next result needs the slot
// reset is synchronous, active low, and empties the file state at once
module linear_interp_resampler_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // input items
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // [23:0] sample_in
  input  logic                       in_tlast,   // last_in
  // result items
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // [23:0] sample_out
  output logic                       out_tlast,  // done_res
  output logic [1:0]                 out_tuser,  // [0] has_sample, [1] too_short
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lir_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [lir_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [lir_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import lir_pkg::*;

  lir_cfg_t                   cfg;
  lir_mul_req_t               mul_req;
  logic                       mul_valid;
  logic signed [SAMPLE_W-1:0] mul_value;

  // register file
  lir_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // shared multiply-round unit, one interpolation per request
  lir_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mul_req),
    .res_valid (mul_valid),
    .res_value (mul_value)
  );

  // sequencer: sample history, output position, result staging
  lir_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .mul_req    (mul_req),
    .mul_valid  (mul_valid),
    .mul_value  (mul_value)
  );

endmodule

/* hw/rtl/lir_cfg.sv */
// lir_cfg: apb register file for ratio_step and max_source
// depends on lir_pkg
module lir_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lir_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [lir_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [lir_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output lir_pkg::lir_cfg_t          cfg
);
  import lir_pkg::*;

  logic [RATIO_W-1:0] ratio_r;
  logic [COUNT_W-1:0] max_r;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
      max_r   <= MAX_RESET;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_RATIO_STEP: ratio_r <= cfg_pwdata[RATIO_W-1:0];
        REG_MAX_SOURCE: max_r   <= cfg_pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_RATIO_STEP: cfg_prdata = DATA_W'(ratio_r);
      REG_MAX_SOURCE: cfg_prdata = DATA_W'(max_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.ratio_step = ratio_r;
  assign cfg.max_source = max_r;

endmodule

/* hw/rtl/lir_interp.sv */
// lir_interp: shared two-stage unit, a + round(frac * (b - a)) with ties away from a
// depends on lir_pkg
module lir_interp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lir_pkg::lir_mul_req_t               req,
  output logic                                res_valid,
  output logic signed [lir_pkg::SAMPLE_W-1:0] res_value
);
  import lir_pkg::*;

  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

  logic signed [SAMPLE_W:0]   diff;
  logic                       neg;
  logic [SAMPLE_W-1:0]        mag;
  logic [PROD_W-1:0]          prod_nxt;

  logic                       s1_valid_r;
  logic [PROD_W-1:0]          prod_r;
  logic                       neg_r;
  logic signed [SAMPLE_W-1:0] a_r;

  logic [PROD_W-1:0]          rnd;
  logic [SAMPLE_W-1:0]        q;
  logic signed [SAMPLE_W+1:0] sum;

  logic                       res_valid_r;
  logic signed [SAMPLE_W-1:0] res_value_r;

  // stage 1: magnitude of the difference times the fraction
  always_comb begin
    diff     = (SAMPLE_W+1)'(req.b) - (SAMPLE_W+1)'(req.a);
    neg      = diff[SAMPLE_W];
    mag      = neg ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
    prod_nxt = PROD_W'(mag) * PROD_W'(req.frac);
  end

  // stage 2: round, then step from a toward b
  always_comb begin
    rnd = prod_r + HALF;
    q   = rnd[PROD_W-1:FRAC_W];
    sum = neg_r ? ((SAMPLE_W+2)'(a_r) - (SAMPLE_W+2)'({1'b0, q}))
                : ((SAMPLE_W+2)'(a_r) + (SAMPLE_W+2)'({1'b0, q}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= req.start;
      res_valid_r <= s1_valid_r;
    end
    prod_r      <= prod_nxt;
    neg_r       <= neg;
    a_r         <= req.a;
    res_value_r <= sum[SAMPLE_W-1:0];
  end

  assign res_valid = res_valid_r;
  assign res_value = res_value_r;

endmodule

/* hw/rtl/lir_ctrl.sv */
// lir_ctrl: sequencer, file state, pending result and output register
// depends on lir_pkg; drives the shared lir_interp unit
module lir_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lir_pkg::lir_cfg_t                   cfg,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lir_pkg::SAMPLE_W-1:0]        in_tdata,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lir_pkg::SAMPLE_W-1:0]        out_tdata,
  output logic                                out_tlast,
  output logic [1:0]                          out_tuser,
  output lir_pkg::lir_mul_req_t               mul_req,
  input  logic                                mul_valid,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] mul_value
);
  import lir_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_WAIT, ST_FIN} state_t;

  state_t                     state_r;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] curr_r;
  logic [COUNT_W-1:0]         cnt_r;
  logic [POS_W-1:0]           pos_r;
  logic [1:0]                 outcnt_r;      // saturates at two
  logic [RES_CNT_W-1:0]       res_cnt_r;
  logic signed [SAMPLE_W-1:0] held_r;
  logic                       held_valid_r;
  logic signed [SAMPLE_W-1:0] pend_sample_r;
  logic                       pend_valid_r;
  logic                       out_valid_r;
  logic [SAMPLE_W-1:0]        out_data_r;
  logic                       out_last_r;
  logic [1:0]                 out_user_r;

  logic [POS_W:0]             pos_nxt;
  logic [POS_W:0]             limit;
  logic [COUNT_W-1:0]         idx;
  logic [COUNT_W-1:0]         cnt_m2;
  logic                       exists;
  logic                       need_held;
  logic                       cap_hit;
  logic                       res_full;
  logic                       out_free;
  logic                       out_load;
  logic signed [SAMPLE_W-1:0] emit_value;
  logic [1:0]                 outcnt_nxt;

  always_comb begin
    pos_nxt    = (POS_W+1)'(pos_r) + (POS_W+1)'(cfg.ratio_step);
    limit      = {1'b0, cnt_r, {FRAC_W{1'b0}}};
    exists     = pos_nxt <= limit;
    idx        = pos_r[POS_W-1:FRAC_W];
    cnt_m2     = cnt_r - COUNT_W'(2);
    need_held  = !held_valid_r && (cnt_r >= COUNT_W'(2)) && (idx <= cnt_m2);
    cap_hit    = (cnt_r >= cfg.max_source) || (&cnt_r);
    res_full   = res_cnt_r == RES_CNT_W'(RES_LIMIT);
    out_free   = !out_valid_r || out_tready;
    emit_value = held_valid_r ? held_r : '0;
    outcnt_nxt = outcnt_r[1] ? outcnt_r : outcnt_r + 2'd1;
    // the output register takes a new item this cycle
    out_load   = ((state_r == ST_EVAL) && !res_full && !need_held && exists &&
                  (held_valid_r || last_r) && pend_valid_r && out_free) ||
                 ((state_r == ST_FIN) && out_free && (last_r || pend_valid_r));
  end

  always_comb begin
    mul_req.start = (state_r == ST_EVAL) && !res_full && need_held;
    mul_req.a     = prev_r;
    mul_req.b     = curr_r;
    mul_req.frac  = pos_r[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      last_r        <= 1'b0;
      prev_r        <= '0;
      curr_r        <= '0;
      cnt_r         <= '0;
      pos_r         <= '0;
      outcnt_r      <= '0;
      res_cnt_r     <= '0;
      held_r        <= '0;
      held_valid_r  <= 1'b0;
      pend_sample_r <= '0;
      pend_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      out_data_r    <= '0;
      out_last_r    <= 1'b0;
      out_user_r    <= '0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            last_r    <= in_tlast;
            res_cnt_r <= '0;
            if (!cap_hit) begin
              prev_r <= curr_r;
              curr_r <= in_tdata;
              cnt_r  <= cnt_r + COUNT_W'(1);
            end
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (res_full) begin
            state_r <= ST_FIN;
          end else if (need_held) begin
            state_r <= ST_WAIT;
          end else if (!exists || (!held_valid_r && !last_r)) begin
            state_r <= ST_FIN;
          end else if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              out_valid_r <= 1'b1;
              out_data_r  <= pend_sample_r;
              out_last_r  <= 1'b0;
              out_user_r  <= 2'b01;
            end
            pend_sample_r <= emit_value;
            pend_valid_r  <= 1'b1;
            res_cnt_r     <= res_cnt_r + RES_CNT_W'(1);
            held_valid_r  <= 1'b0;
            pos_r         <= pos_nxt[POS_W-1:0];
            outcnt_r      <= outcnt_nxt;
          end
        end
        ST_WAIT: begin
          if (mul_valid) begin
            held_r       <= mul_value;
            held_valid_r <= 1'b1;
            state_r      <= ST_EVAL;
          end
        end
        ST_FIN: begin
          if (last_r) begin
            if (out_free) begin
              // final result of the file, then back to an empty file
              out_valid_r  <= 1'b1;
              out_data_r   <= pend_valid_r ? pend_sample_r : '0;
              out_last_r   <= 1'b1;
              out_user_r   <= {!outcnt_r[1], pend_valid_r};
              pend_valid_r <= 1'b0;
              prev_r       <= '0;
              curr_r       <= '0;
              cnt_r        <= '0;
              pos_r        <= '0;
              outcnt_r     <= '0;
              held_valid_r <= 1'b0;
              state_r      <= ST_IDLE;
            end
          end else if (!pend_valid_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= pend_sample_r;
            out_last_r   <= 1'b0;
            out_user_r   <= 2'b01;
            pend_valid_r <= 1'b0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RES_CNT_W'(RES_LIMIT))
    else $error("result count past the per-item limit");

  a_pend_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_valid_r)
    else $error("pending result left over between items");

  a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("result without sample that does not end the file");

  a_held_from_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(held_valid_r) |-> $past(mul_valid))
    else $error("held value set without interpolation result");

  a_unit_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mul_valid |-> (state_r == ST_WAIT))
    else $error("interpolation result outside the wait state");
`endif

endmodule

/* tb/sv/lir_checker.sv */
// lir_checker: watches the input, result and register ports of the resampler,
// predicts every result item and compares it field by field
// depends on lir_pkg
`timescale 1ns / 100ps

module lir_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [23:0]                in_tdata,   // [23:0] sample_in
  input  logic                       in_tlast,   // last_in
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [23:0]                out_tdata,  // [23:0] sample_out
  input  logic                       out_tlast,  // done_res
  input  logic [1:0]                 out_tuser,  // [0] has_sample, [1] too_short
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [lir_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [lir_pkg::DATA_W-1:0] cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         mismatches,
  output int                         pending
);
  import lir_pkg::*;

  localparam int MAX_PRINT = 100;
  localparam int OUT_CNT_W = 28;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                has_sample;
    logic                done;
    logic                too_short;
  } lir_res_t;

  // register copies
  logic [RATIO_W-1:0]         step_q;
  logic [COUNT_W-1:0]         src_cap;

  // file state
  logic signed [SAMPLE_W-1:0] older_smp;
  logic signed [SAMPLE_W-1:0] newer_smp;
  logic [COUNT_W-1:0]         src_cnt;
  logic [POS_W-1:0]           next_pos;
  logic [OUT_CNT_W-1:0]       out_cnt;
  logic                       capped;
  logic signed [SAMPLE_W-1:0] held_val;
  logic                       held_ok;

  lir_res_t resampled_q[$];
  lir_res_t want;

  task automatic restart_file();
    older_smp = '0;
    newer_smp = '0;
    src_cnt   = '0;
    next_pos  = '0;
    out_cnt   = '0;
    capped    = 1'b0;
    held_val  = '0;
    held_ok   = 1'b0;
  endtask

  // a + frac * (b - a), the product rounded to nearest with ties away from a
  function automatic logic [SAMPLE_W-1:0] lerp(input logic signed [SAMPLE_W-1:0] a,
                                               input logic signed [SAMPLE_W-1:0] b,
                                               input logic [FRAC_W-1:0] f);
    longint d;
    longint unsigned m;
    longint unsigned q;
    longint y;
    d = longint'(b) - longint'(a);
    m = (d < 0) ? -d : d;
    q = (m * f + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
    y = (d < 0) ? longint'(a) - longint'(q) : longint'(a) + longint'(q);
    return y[SAMPLE_W-1:0];
  endfunction

  task automatic resample_item(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int n;
    bit stop;
    logic shrt;
    longint unsigned pos;
    longint unsigned cnt;
    longint unsigned idx;
    lir_res_t batch [RES_LIMIT];
    n = 0;
    stop = 1'b0;
    if (src_cnt >= src_cap || src_cnt == '1) begin
      capped = 1'b1;
    end else begin
      older_smp = newer_smp;
      newer_smp = smp;
      src_cnt++;
    end
    while (n < RES_LIMIT && !stop) begin
      cnt = 64'(src_cnt);
      pos = 64'(next_pos);
      idx = pos >> FRAC_W;
      if (!held_ok && cnt >= 2 && idx <= cnt - 2) begin
        held_val = lerp(older_smp, newer_smp, pos[FRAC_W-1:0]);
        held_ok  = 1'b1;
      end
      if (pos + step_q > (cnt << FRAC_W)) begin
        stop = 1'b1;
      end else if (!held_ok && !lst) begin
        stop = 1'b1;
      end else begin
        // no held value on the final item means the final interval
        batch[n].value      = held_ok ? held_val : '0;
        batch[n].has_sample = 1'b1;
        batch[n].done       = 1'b0;
        batch[n].too_short  = 1'b0;
        n++;
        held_ok  = 1'b0;
        next_pos = POS_W'(pos + step_q);
        if (out_cnt != '1) out_cnt++;
      end
    end
    if (lst) begin
      shrt = (out_cnt <= 1);
      if (n == 0) begin
        batch[0].value      = '0;
        batch[0].has_sample = 1'b0;
        batch[0].done       = 1'b1;
        batch[0].too_short  = shrt;
        n = 1;
      end else begin
        batch[n-1].done      = 1'b1;
        batch[n-1].too_short = shrt;
      end
      restart_file();
    end
    for (int k = 0; k < n; k++) resampled_q.insert(resampled_q.size(), batch[k]);
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
    mismatches++;
    if (mismatches <= MAX_PRINT)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      step_q  = RATIO_RESET;
      src_cap = MAX_RESET;
      restart_file();
      resampled_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_RATIO_STEP) step_q = cfg_pwdata[RATIO_W-1:0];
        else src_cap = cfg_pwdata[COUNT_W-1:0];
      end
      if (in_tvalid && in_tready) resample_item(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (resampled_q.size() == 0) begin
          flag_mismatch("result with nothing expected", out_tdata, 0);
        end else begin
          want = resampled_q.pop_front();
          if (out_tdata !== want.value) flag_mismatch("sample_out", out_tdata, want.value);
          if (out_tuser[0] !== want.has_sample)
            flag_mismatch("has_sample", out_tuser[0], want.has_sample);
          if (out_tlast !== want.done) flag_mismatch("done_res", out_tlast, want.done);
          if (out_tuser[1] !== want.too_short)
            flag_mismatch("too_short", out_tuser[1], want.too_short);
        end
      end
    end
    pending <= resampled_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// tb_top: stimulus and verdict for linear_interp_resampler_top; the checker
// beside the block predicts and compares every result item
// depends on lir_pkg, lir_checker and the block
`timescale 1ns / 100ps

module tb_top;
  import lir_pkg::*;

  localparam int RAND_ITEMS    = 480;
  localparam int SETTLE_CYCLES = 300;      // room for the longest item, one with 64 results
  localparam int CYCLE_LIMIT   = 1500000;

  // ratio_step is unsigned q6.24
  localparam logic [31:0] RATIO_ONE = 32'd16777216;
  localparam logic [31:0] RATIO_LO  = 32'd524288;      // 1/32
  localparam logic [31:0] RATIO_HI  = 32'd536870912;   // 32
  localparam logic [31:0] CAP_HI    = 32'd8388607;

  localparam logic [23:0] SMP_MAX = 24'h7FFFFF;
  localparam logic [23:0] SMP_MIN = 24'h800000;

  typedef enum int {SM_NOISE, SM_EDGE, SM_TINY, SM_RAMP} sample_style_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;      // [23:0] sample_in
  logic              in_tlast = 1'b0;    // last_in
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [23:0]       out_tdata;          // [23:0] sample_out
  logic              out_tlast;          // done_res
  logic [1:0]        out_tuser;          // [0] has_sample, [1] too_short
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  int  mismatch_cnt;
  int  pending_cnt;
  int  cycles = 0;
  int  fed = 0;             // random items that the block takes in, dropped ones aside
  int  cur_cap = CAP_HI;    // max_source as last written
  bit  steady = 1'b0;       // no idling on either side while set

  always #2 clk = ~clk;

  linear_interp_resampler_top dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  lir_checker chk (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .mismatches(mismatch_cnt),
    .pending(pending_cnt)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("linear_interp_resampler_top verification failed");
      $finish;
    end
  end

  // result side: a fresh random stall before every result item,
  // none while steady is set
  initial begin
    int gap;
    forever begin
      gap = steady ? 0 : $urandom_range(3, 0);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // one input item, after a random gap; tvalid stays high into the
  // next item when that one draws no gap
  task automatic send_item(input logic [23:0] smp, input logic lst);
    int gap;
    gap = steady ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  // apb write: setup cycle, then access cycle
  task automatic cfg_write(input logic sel, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (sel == REG_MAX_SOURCE) cur_cap = val;
  endtask

  // let the block drain: every predicted item back, then room for an item
  // that is still being worked without giving any result
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly moderate ratios, with the extremes and exact values now and then
  function automatic logic [31:0] pick_ratio();
    case ($urandom_range(9, 0))
      0:       return RATIO_LO;
      1:       return RATIO_HI;
      2:       return RATIO_ONE;
      3:       return RATIO_ONE >> 1;
      4, 5, 6: return $urandom_range(2 * RATIO_ONE, RATIO_LO);
      default: return $urandom_range(RATIO_HI, RATIO_LO);
    endcase
  endfunction

  // one file of len items; a ratio change lands before item mid_at
  task automatic send_file(input int len, input sample_style_t style, input int mid_at);
    logic [23:0] smp;
    for (int k = 0; k < len; k++) begin
      if (k == mid_at) begin
        settle();
        cfg_write(REG_RATIO_STEP, pick_ratio());
      end
      case (style)
        SM_EDGE: begin
          case ($urandom_range(3, 0))
            0:       smp = SMP_MAX;
            1:       smp = SMP_MIN;
            2:       smp = '0;
            default: smp = '1;
          endcase
        end
        // small values put many products right on a rounding tie
        SM_TINY: smp = 24'(int'($urandom_range(16, 0)) - 8);
        SM_RAMP: smp = 24'(k * 24'h0A3D71);
        default: smp = 24'($urandom);
      endcase
      send_item(smp, k == len - 1);
      if (k < cur_cap) fed++;
    end
  endtask

  initial begin
    int nfiles;
    int len;
    int mid;
    int pick;
    logic [31:0] cap;
    sample_style_t style;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    // reset setting, ratio 1.0: extremes pass straight through, then the
    // final interval gives a zero
    send_item(SMP_MAX, 1'b0);
    send_item(SMP_MIN, 1'b0);
    send_item(SMP_MAX, 1'b1);
    // one-sample file: a single zero output and too_short
    send_item(24'h5A5A5A, 1'b1);

    // ratio 2.0 over two samples: exactly one output
    settle();
    cfg_write(REG_RATIO_STEP, 2 * RATIO_ONE);
    send_item(SMP_MIN, 1'b0);
    send_item(SMP_MAX, 1'b1);

    // ratio change in the middle of a file, 0.75 then 1.5
    settle();
    cfg_write(REG_RATIO_STEP, RATIO_ONE - (RATIO_ONE >> 2));
    send_item(24'd100, 1'b0);
    send_item(24'(-100), 1'b0);
    settle();
    cfg_write(REG_RATIO_STEP, RATIO_ONE + (RATIO_ONE >> 1));
    send_item(24'd7, 1'b0);
    send_item(24'd8, 1'b1);

    // smallest cap: the last two samples are dropped, their last flag still ends the file
    settle();
    cfg_write(REG_RATIO_STEP, RATIO_ONE);
    cfg_write(REG_MAX_SOURCE, 32'd2);
    send_item(24'd1, 1'b0);
    send_item(24'd2, 1'b0);
    send_item(24'd3, 1'b0);
    send_item(24'd4, 1'b1);

    // slowest ratio: the last item gives the full 64 results
    settle();
    cfg_write(REG_MAX_SOURCE, CAP_HI);
    cfg_write(REG_RATIO_STEP, RATIO_LO);
    send_item(SMP_MAX, 1'b0);
    send_item(SMP_MIN, 1'b0);
    send_item(24'd12345, 1'b1);

    // fastest ratio over two samples: no output, a bare done item
    settle();
    cfg_write(REG_RATIO_STEP, RATIO_HI);
    send_item(SMP_MIN, 1'b0);
    send_item(SMP_MAX, 1'b1);

    // random part: phases of a few files each, new setting per phase
    while (fed < RAND_ITEMS) begin
      settle();
      cfg_write(REG_RATIO_STEP, pick_ratio());
      if ($urandom_range(1, 0) == 1) begin
        case ($urandom_range(9, 0))
          0:       cap = 32'd2;
          1, 2:    cap = $urandom_range(12, 2);
          3:       cap = $urandom_range(CAP_HI, 13);
          default: cap = CAP_HI;
        endcase
        cfg_write(REG_MAX_SOURCE, cap);
      end
      steady = ($urandom_range(3, 0) == 0);
      nfiles = $urandom_range(4, 1);
      repeat (nfiles) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) len = 1;
        else if (pick == 1) len = $urandom_range(40, 24);
        else len = $urandom_range(16, 2);
        mid = (len > 2 && $urandom_range(9, 0) == 0) ? $urandom_range(len - 1, 1) : -1;
        pick = $urandom_range(9, 0);
        if (pick < 5) style = SM_NOISE;
        else if (pick < 7) style = SM_EDGE;
        else if (pick < 9) style = SM_TINY;
        else style = SM_RAMP;
        send_file(len, style, mid);
      end
    end

    // drain and give the verdict
    steady = 1'b0;
    settle();
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("linear_interp_resampler_top verification clean");
    end else begin
      $display("linear_interp_resampler_top verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lir_pkg.sv
hw/rtl/lir_cfg.sv
hw/rtl/lir_interp.sv
hw/rtl/lir_ctrl.sv
hw/rtl/linear_interp_resampler_top.sv
tb/sv/lir_checker.sv
tb/sv/tb_top.sv
